[rtl/tbc_pkg.sv]
// Shared types and constants of the transmit backoff controller.
package tbc_pkg;

    localparam int MASK_W    = 16;
    localparam int DELAY_W   = 5;
    localparam int COUNT_W   = 32;
    localparam int BUF_W     = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [MASK_W-1:0]  MASK_ALL   = {MASK_W{1'b1}};
    localparam logic [DELAY_W-1:0] DELAY_BITS = 5'h1f;

    // Register select is the word bit of the byte address.
    localparam logic REG_LINK_RUNNING = 1'b0;
    localparam logic REG_TX_BUFFER    = 1'b1;

    typedef enum logic [1:0] {
        KIND_START     = 2'd0,
        KIND_TX_INT    = 2'd1,
        KIND_COLLISION = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_STARTED = 3'd1,
        ACT_RETRY   = 3'd2,
        ACT_SENDERR = 3'd3,
        ACT_STRAY   = 3'd4,
        ACT_SENT    = 3'd5
    } action_t;

    typedef struct packed {
        logic             link_running;
        logic [BUF_W-1:0] transmit_buffer_index;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               queue_nonempty;
        logic               done_status;
        logic [BUF_W-1:0]   status_buffer;
        logic [DELAY_W-1:0] random_bits;
    } event_t;

    typedef struct packed {
        logic [2:0]         action;
        logic               start_next;
        logic [DELAY_W-1:0] delay_slots;
        logic               busy_res;
        logic [COUNT_W-1:0] collisions_seen;
        logic [COUNT_W-1:0] packets_sent;
        logic [COUNT_W-1:0] send_errors;
    } result_t;

endpackage

[rtl/tbc_if.sv]
// Valid/ready channel interfaces for events and results.
interface tbc_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic                        queue_nonempty;
    logic                        done_status;
    logic [tbc_pkg::BUF_W-1:0]   status_buffer;
    logic [tbc_pkg::DELAY_W-1:0] random_bits;

    modport source (output valid, kind, queue_nonempty, done_status, status_buffer,
                    random_bits, input ready);
    modport sink   (input valid, kind, queue_nonempty, done_status, status_buffer,
                    random_bits, output ready);
endinterface

interface tbc_out_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  action;
    logic                        start_next;
    logic [tbc_pkg::DELAY_W-1:0] delay_slots;
    logic                        busy_res;
    logic [tbc_pkg::COUNT_W-1:0] collisions_seen;
    logic [tbc_pkg::COUNT_W-1:0] packets_sent;
    logic [tbc_pkg::COUNT_W-1:0] send_errors;

    modport source (output valid, action, start_next, delay_slots, busy_res,
                    collisions_seen, packets_sent, send_errors, input ready);
    modport sink   (input valid, action, start_next, delay_slots, busy_res,
                    collisions_seen, packets_sent, send_errors, output ready);
endinterface

[rtl/transmit_backoff_controller.sv]
// Top level of the Ethernet transmit controller with exponential backoff.
//
//   Channel   Direction  Handshake              Content
//   in_ch     in         valid/ready            one event: kind, queue, status, timer bits
//   out_ch    out        valid/ready            one result item per event
//   APB       in/out     psel/penable, pready   link_running, transmit_buffer_index
//
// Every accepted event is decided in the cycle it is accepted: the backoff mask,
// active flag and counters update at that clock edge and the result item is
// written into a two-entry output buffer, so one event per clock is sustained
// while out_ch takes results. A result item appears on out_ch once the items
// before it are taken. in_ch.ready drops only when both buffer entries hold
// results not yet taken. Reset is asynchronous and active low; it clears the
// flag, counters and registers and sets the backoff mask to all ones.
module transmit_backoff_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    tbc_in_if.sink                         in_ch,
    tbc_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tbc_pkg::*;

    cfg_t    cfg;
    event_t  ev;
    result_t core_result;
    result_t head;
    logic    accept;
    logic    pop;
    logic    has_room;
    logic    not_empty;

    // Configuration registers live behind the APB port.
    tbc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The event is taken whenever the output buffer can hold its result.
    assign in_ch.ready = has_room;
    assign accept      = in_ch.valid && has_room;

    assign ev.kind           = in_ch.kind;
    assign ev.queue_nonempty = in_ch.queue_nonempty;
    assign ev.done_status    = in_ch.done_status;
    assign ev.status_buffer  = in_ch.status_buffer;
    assign ev.random_bits    = in_ch.random_bits;

    tbc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ev     (ev),
        .cfg    (cfg),
        .result (core_result)
    );

    // The buffer head drives the result channel directly.
    assign pop = out_ch.ready && not_empty;

    tbc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .pop       (pop),
        .has_room  (has_room),
        .not_empty (not_empty),
        .head      (head)
    );

    assign out_ch.valid           = not_empty;
    assign out_ch.action          = head.action;
    assign out_ch.start_next      = head.start_next;
    assign out_ch.delay_slots     = head.delay_slots;
    assign out_ch.busy_res        = head.busy_res;
    assign out_ch.collisions_seen = head.collisions_seen;
    assign out_ch.packets_sent    = head.packets_sent;
    assign out_ch.send_errors     = head.send_errors;

    // Every accepted event leaves a result item waiting in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_ch.valid)
        else $error("accepted event produced no result item");

    // A backoff delay is reported only with a retry action.
    a_delay_only_retry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.delay_slots != '0)) |-> (out_ch.action == ACT_RETRY))
        else $error("nonzero delay without retry action");

    // A packet started by an event leaves the transmitter active.
    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.start_next) |-> out_ch.busy_res)
        else $error("start reported while transmitter idle");

    // A retry keeps the transmitter active and starts nothing.
    a_retry_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.action == ACT_RETRY)) |-> (out_ch.busy_res && !out_ch.start_next))
        else $error("retry result with inconsistent active flag");

endmodule

[rtl/tbc_cfg_regs.sv]
// APB configuration registers of the transmit backoff controller.
module tbc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tbc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tbc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tbc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output tbc_pkg::cfg_t                     cfg
);
    import tbc_pkg::*;

    logic             link_running_reg;
    logic             link_running_next;
    logic [BUF_W-1:0] tx_buffer_reg;
    logic [BUF_W-1:0] tx_buffer_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        link_running_next = link_running_reg;
        tx_buffer_next    = tx_buffer_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_LINK_RUNNING: link_running_next = pwdata[0];
                REG_TX_BUFFER:    tx_buffer_next    = pwdata[BUF_W-1:0];
                default:          link_running_next = link_running_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_running_reg <= 1'b0;
            tx_buffer_reg    <= '0;
        end
        else
        begin
            link_running_reg <= link_running_next;
            tx_buffer_reg    <= tx_buffer_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LINK_RUNNING: prdata = {{(APB_DATA_W-1){1'b0}}, link_running_reg};
            REG_TX_BUFFER:    prdata = {{(APB_DATA_W-BUF_W){1'b0}}, tx_buffer_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.link_running          = link_running_reg;
    assign cfg.transmit_buffer_index = tx_buffer_reg;

endmodule

[rtl/tbc_core.sv]
// Backoff state, counters and per-event decision logic.
module tbc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  tbc_pkg::event_t  ev,
    input  tbc_pkg::cfg_t    cfg,
    output tbc_pkg::result_t result
);
    import tbc_pkg::*;

    logic               tx_active_reg;
    logic               tx_active_next;
    logic [MASK_W-1:0]  mask_reg;
    logic [MASK_W-1:0]  mask_next;
    logic [COUNT_W-1:0] coll_reg;
    logic [COUNT_W-1:0] coll_next;
    logic [COUNT_W-1:0] sent_reg;
    logic [COUNT_W-1:0] sent_next;
    logic [COUNT_W-1:0] err_reg;
    logic [COUNT_W-1:0] err_next;
    action_t            action;
    logic               started;
    logic [DELAY_W-1:0] delay;
    logic               can_start;

    // A queued packet starts only when the link runs.
    assign can_start = cfg.link_running && ev.queue_nonempty;

    always_comb
    begin
        tx_active_next = tx_active_reg;
        mask_next      = mask_reg;
        coll_next      = coll_reg;
        sent_next      = sent_reg;
        err_next       = err_reg;
        action         = ACT_NONE;
        started        = 1'b0;
        delay          = '0;
        case (kind_t'(ev.kind))
            KIND_START:
            begin
                if (!tx_active_reg && cfg.link_running)
                begin
                    tx_active_next = ev.queue_nonempty;
                    started        = ev.queue_nonempty;
                    if (ev.queue_nonempty)
                    begin
                        action = ACT_STARTED;
                    end
                end
            end
            KIND_TX_INT:
            begin
                if (tx_active_reg)
                begin
                    if (!ev.done_status ||
                        (ev.status_buffer != cfg.transmit_buffer_index))
                    begin
                        tx_active_next = 1'b0;
                        action         = ACT_STRAY;
                    end
                    else
                    begin
                        sent_next      = sent_reg + 1'b1;
                        mask_next      = MASK_ALL;
                        action         = ACT_SENT;
                        started        = can_start;
                        tx_active_next = can_start;
                    end
                end
            end
            KIND_COLLISION:
            begin
                coll_next = coll_reg + 1'b1;
                if (tx_active_reg)
                begin
                    if (mask_reg == '0)
                    begin
                        err_next       = err_reg + 1'b1;
                        mask_next      = MASK_ALL;
                        action         = ACT_SENDERR;
                        started        = can_start;
                        tx_active_next = can_start;
                    end
                    else
                    begin
                        mask_next = {mask_reg[MASK_W-2:0], 1'b0};
                        delay     = ev.random_bits & DELAY_BITS & ~mask_next[DELAY_W-1:0];
                        action    = ACT_RETRY;
                    end
                end
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_active_reg <= 1'b0;
            mask_reg      <= MASK_ALL;
            coll_reg      <= '0;
            sent_reg      <= '0;
            err_reg       <= '0;
        end
        else if (accept)
        begin
            tx_active_reg <= tx_active_next;
            mask_reg      <= mask_next;
            coll_reg      <= coll_next;
            sent_reg      <= sent_next;
            err_reg       <= err_next;
        end
    end

    assign result.action          = action;
    assign result.start_next      = started;
    assign result.delay_slots     = delay;
    assign result.busy_res        = tx_active_next;
    assign result.collisions_seen = coll_next;
    assign result.packets_sent    = sent_next;
    assign result.send_errors     = err_next;

endmodule

[rtl/tbc_out_buf.sv]
// Two-entry result buffer that decouples the event and result channels.
module tbc_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tbc_pkg::result_t push_data,
    input  logic             pop,
    output logic             has_room,
    output logic             not_empty,
    output tbc_pkg::result_t head
);
    import tbc_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign has_room  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[verif/transmit_backoff_controller_tb.sv]
// Self-checking testbench of the transmit backoff controller, predicting every result item.
module transmit_backoff_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbc_pkg::*;

    // Kind code that the block must ignore; the package leaves it unnamed.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    tbc_in_if  in_ch ();
    tbc_out_if out_ch ();

    transmit_backoff_controller i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the block state and its two registers, kept by the predictor.
    logic               busy_mirror;
    logic [MASK_W-1:0]  mask_mirror;
    logic [COUNT_W-1:0] collision_count;
    logic [COUNT_W-1:0] sent_count;
    logic [COUNT_W-1:0] error_count;
    logic               link_cfg;
    logic [BUF_W-1:0]   txbuf_cfg;

    // Results predicted for accepted items, oldest first.
    result_t awaited_outcomes[$];

    int n_failures;
    int src_gap_pct;
    int snk_stall_pct;

    always #5 clk = ~clk;

    // The result channel stalls at random; the percentage changes per phase.
    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Counts one failure and reports it while the report budget lasts.
    task automatic flag_failure(input string msg);
        n_failures++;
        if (n_failures <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
        begin
            flag_failure($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
        end
    endtask

    // Starts the queued packet when the link runs; returns 1 when it did.
    // An empty queue with the link up also clears the active flag.
    function automatic logic launch_queued(input logic queued);
        if (!link_cfg)
        begin
            return 1'b0;
        end
        if (!queued)
        begin
            busy_mirror = 1'b0;
            return 1'b0;
        end
        busy_mirror = 1'b1;
        return 1'b1;
    endfunction

    // Applies one event to the mirrored state and returns the result item it causes.
    function automatic result_t backoff_outcome(input event_t ev);
        result_t r;
        r = '0;
        r.action = ACT_NONE;
        case (ev.kind)
            KIND_START:
            begin
                // A start request while a packet is in flight is dropped.
                if (!busy_mirror)
                begin
                    r.start_next = launch_queued(ev.queue_nonempty);
                    if (r.start_next)
                    begin
                        r.action = ACT_STARTED;
                    end
                end
            end
            KIND_TX_INT:
            begin
                if (busy_mirror)
                begin
                    if (!ev.done_status || ev.status_buffer != txbuf_cfg)
                    begin
                        // Stray interrupt: the backoff mask survives it.
                        busy_mirror = 1'b0;
                        r.action = ACT_STRAY;
                    end
                    else
                    begin
                        sent_count++;
                        busy_mirror = 1'b0;
                        mask_mirror = MASK_ALL;
                        r.action = ACT_SENT;
                        if (ev.queue_nonempty)
                        begin
                            r.start_next = launch_queued(1'b1);
                        end
                    end
                end
            end
            KIND_COLLISION:
            begin
                collision_count++;
                if (busy_mirror)
                begin
                    if (mask_mirror == '0)
                    begin
                        // Sixteen backoffs used up: the packet is dropped.
                        error_count++;
                        busy_mirror = 1'b0;
                        mask_mirror = MASK_ALL;
                        r.action = ACT_SENDERR;
                        if (ev.queue_nonempty)
                        begin
                            r.start_next = launch_queued(1'b1);
                        end
                    end
                    else
                    begin
                        mask_mirror = mask_mirror << 1;
                        r.delay_slots = ev.random_bits & DELAY_BITS & ~mask_mirror[DELAY_W-1:0];
                        r.action = ACT_RETRY;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.busy_res        = busy_mirror;
        r.collisions_seen = collision_count;
        r.packets_sent    = sent_count;
        r.send_errors     = error_count;
        return r;
    endfunction

    // Each result item taken from the block is checked against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_t seen;
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen.action          = out_ch.action;
            seen.start_next      = out_ch.start_next;
            seen.delay_slots     = out_ch.delay_slots;
            seen.busy_res        = out_ch.busy_res;
            seen.collisions_seen = out_ch.collisions_seen;
            seen.packets_sent    = out_ch.packets_sent;
            seen.send_errors     = out_ch.send_errors;
            if (awaited_outcomes.size() == 0)
            begin
                flag_failure("result item arrived with no event outstanding");
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                compare_field("action", seen.action, want.action);
                compare_field("start_next", seen.start_next, want.start_next);
                compare_field("delay_slots", seen.delay_slots, want.delay_slots);
                compare_field("busy_res", seen.busy_res, want.busy_res);
                compare_field("collisions_seen", seen.collisions_seen, want.collisions_seen);
                compare_field("packets_sent", seen.packets_sent, want.packets_sent);
                compare_field("send_errors", seen.send_errors, want.send_errors);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance,
    // with valid still high so that the next item can follow without a gap.
    task automatic send_event(input event_t ev);
        while ($urandom_range(99) < src_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= ev.kind;
        in_ch.queue_nonempty <= ev.queue_nonempty;
        in_ch.done_status    <= ev.done_status;
        in_ch.status_buffer  <= ev.status_buffer;
        in_ch.random_bits    <= ev.random_bits;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        awaited_outcomes.push_back(backoff_outcome(ev));
        @(negedge clk);
    endtask

    function automatic event_t make_event(input logic [1:0] kind, input logic queued,
                                          input logic done, input logic [3:0] sbuf,
                                          input logic [4:0] rnd);
        event_t ev;
        ev.kind           = kind;
        ev.queue_nonempty = queued;
        ev.done_status    = done;
        ev.status_buffer  = sbuf;
        ev.random_bits    = rnd;
        return ev;
    endfunction

    function automatic event_t random_event(input logic [1:0] kind);
        return make_event(kind, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          4'($urandom_range(15)), 5'($urandom_range(31)));
    endfunction

    // Holds the sender off until every predicted result has been taken.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    // Leaves the bus idle before it returns, so a following
    // transfer starts in a fresh cycle.
    task automatic apb_write(input logic reg_sel, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_read(input logic reg_sel, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Reads both registers back and compares them with the mirrored values.
    task automatic check_registers();
        logic [APB_DATA_W-1:0] rd;
        apb_read(REG_LINK_RUNNING, rd);
        compare_field("link_running readback", rd, {31'b0, link_cfg});
        apb_read(REG_TX_BUFFER, rd);
        compare_field("transmit_buffer_index readback", rd, {28'b0, txbuf_cfg});
    endtask

    // Waits first until no result is outstanding, so the mirror and the
    // block switch to the new setting between the same two items.
    task automatic program_link(input logic link, input logic [BUF_W-1:0] tx_buffer);
        wait_for_results();
        apb_write(REG_LINK_RUNNING, {31'b0, link});
        link_cfg = link;
        apb_write(REG_TX_BUFFER, {28'b0, tx_buffer});
        txbuf_cfg = tx_buffer;
        check_registers();
    endtask

    // Straight after reset the link is down: nothing may start, a transmit
    // interrupt is ignored and so is kind 3, and a collision is only counted.
    task automatic test_link_down_after_reset();
        check_registers();
        send_event(make_event(KIND_START, 1'b1, 1'b1, 4'd0, 5'd31));
        send_event(make_event(KIND_TX_INT, 1'b1, 1'b1, 4'd0, 5'd0));
        send_event(make_event(KIND_COLLISION, 1'b1, 1'b0, 4'd15, 5'd31));
        send_event(make_event(KIND_UNUSED, 1'b1, 1'b1, 4'd15, 5'd31));
    endtask

    // Every transmit path with the highest buffer number: empty queue,
    // start, start while busy, stray on status and on buffer, one retry,
    // good transmit with and without a follow-up packet.
    task automatic test_transmit_paths();
        program_link(1'b1, 4'd15);
        send_event(make_event(KIND_START, 1'b0, 1'b0, 4'd0, 5'd0));
        send_event(make_event(KIND_START, 1'b1, 1'b0, 4'd0, 5'd0));
        send_event(make_event(KIND_START, 1'b1, 1'b1, 4'd15, 5'd31));
        send_event(make_event(KIND_TX_INT, 1'b0, 1'b0, 4'd15, 5'd0));
        send_event(make_event(KIND_START, 1'b1, 1'b0, 4'd0, 5'd0));
        send_event(make_event(KIND_TX_INT, 1'b1, 1'b1, 4'd7, 5'd0));
        send_event(make_event(KIND_START, 1'b1, 1'b0, 4'd0, 5'd0));
        send_event(make_event(KIND_COLLISION, 1'b0, 1'b0, 4'd0, 5'd31));
        send_event(make_event(KIND_TX_INT, 1'b1, 1'b1, 4'd15, 5'd0));
        send_event(make_event(KIND_TX_INT, 1'b0, 1'b1, 4'd15, 5'd31));
    endtask

    // Seventeen collisions on one packet: sixteen backoffs whose delay range
    // widens up to five bits, then a drop that counts a send error and starts the next packet.
    task automatic test_backoff_exhaustion();
        program_link(1'b1, 4'd0);
        send_event(make_event(KIND_START, 1'b1, 1'b0, 4'd0, 5'd0));
        for (int i = 0; i < 17; i++)
        begin
            send_event(make_event(KIND_COLLISION, i == 16, 1'b0, 4'd0,
                                  (i % 2 == 0) ? 5'd31 : 5'd0));
        end
        send_event(make_event(KIND_TX_INT, 1'b0, 1'b1, 4'd0, 5'd0));
    endtask

    // Mostly whole packets (start, a run of collisions, a closing transmit
    // interrupt) with random content, mixed with loose random events.
    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int n_items);
        int     sent;
        int     n_coll;
        int     pick;
        event_t ev;
        src_gap_pct   = gap_pct;
        snk_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 20)
            begin
                if ($urandom_range(99) < 5)
                begin
                    ev = random_event(KIND_UNUSED);
                end
                else
                begin
                    ev = random_event(2'($urandom_range(2)));
                end
                send_event(ev);
                sent++;
            end
            else
            begin
                ev = random_event(KIND_START);
                ev.queue_nonempty = 1'b1;
                send_event(ev);
                sent++;
                // Short runs, long runs, and runs that use up all backoffs.
                pick = $urandom_range(9);
                if (pick < 3)
                begin
                    n_coll = $urandom_range(3);
                end
                else if (pick < 7)
                begin
                    n_coll = $urandom_range(15, 4);
                end
                else
                begin
                    n_coll = $urandom_range(20, 16);
                end
                repeat (n_coll)
                begin
                    send_event(random_event(KIND_COLLISION));
                    sent++;
                end
                ev = random_event(KIND_TX_INT);
                if ($urandom_range(99) < 75)
                begin
                    ev.done_status   = 1'b1;
                    ev.status_buffer = txbuf_cfg;
                end
                send_event(ev);
                sent++;
            end
            // Now and then the sender waits for the result channel to drain.
            if ($urandom_range(199) == 0)
            begin
                wait_for_results();
            end
        end
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.kind           = KIND_START;
        in_ch.queue_nonempty = 1'b0;
        in_ch.done_status    = 1'b0;
        in_ch.status_buffer  = '0;
        in_ch.random_bits    = '0;
        out_ch.ready         = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        busy_mirror          = 1'b0;
        mask_mirror          = MASK_ALL;
        collision_count      = '0;
        sent_count           = '0;
        error_count          = '0;
        link_cfg             = 1'b0;
        txbuf_cfg            = '0;
        n_failures           = 0;
        src_gap_pct          = 0;
        snk_stall_pct        = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_link_down_after_reset();
        test_transmit_paths();
        test_backoff_exhaustion();

        program_link(1'b1, 4'($urandom_range(14, 1)));
        test_random_traffic(12, 65, 560);
        program_link(1'b1, 4'd0);
        test_random_traffic(65, 12, 560);
        // With the link down nothing new may start; in-flight packets still finish.
        program_link(1'b0, 4'd15);
        test_random_traffic(0, 0, 60);
        program_link(1'b1, 4'd15);
        test_random_traffic(0, 0, 560);

        wait_for_results();
        repeat (4) @(posedge clk);
        if (n_failures == 0)
        begin
            $display("transmit_backoff_controller_tb passed");
        end
        else
        begin
            $display("transmit_backoff_controller_tb failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("transmit_backoff_controller_tb failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/tbc_pkg.sv
rtl/tbc_if.sv
rtl/tbc_cfg_regs.sv
rtl/tbc_core.sv
rtl/tbc_out_buf.sv
rtl/transmit_backoff_controller.sv
verif/transmit_backoff_controller_tb.sv
